/* hdl/mtrd_pkg.sv */
// ----------------------------------------------------------------------------
// mtrd_pkg
// Types and constants shared by the run-length track decoder.
// ----------------------------------------------------------------------------
package mtrd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 15;
   localparam int unsigned ERR_W   = 3;
   localparam int unsigned LEN_W   = 16;

   localparam logic [COUNT_W-1:0] TRACK_BYTES_RESET = 15'd4608;
   localparam logic [BYTE_W-1:0]  RUN_MARKER        = 8'hE5;
   localparam logic [LEN_W-1:0]   GROUP_BYTES       = 16'd4;

   localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_RUN   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MISMATCH  = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] stream_byte;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  run_value;
      logic [COUNT_W-1:0] run_count;
      logic               track_done;
      logic [ERR_W-1:0]   error_code;
   } rsp_type;

endpackage

/* hdl/mtrd_core.sv */
// ----------------------------------------------------------------------------
// mtrd_core
// Track parsing state and the single-pass decision for one stream byte.
// ----------------------------------------------------------------------------
module mtrd_core
   import mtrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  req_type            req,
   input  logic [COUNT_W-1:0] track_bytes,
   output logic               produce,
   output rsp_type            result
);

   typedef enum logic [2:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_FILL,
      PH_CNT_HI,
      PH_CNT_LO
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  packed_left_ff, packed_left_in;
   logic [LEN_W-1:0]  bytes_made_ff, bytes_made_in;
   logic              raw_track_ff, raw_track_in;
   logic [BYTE_W-1:0] held_fill_ff, held_fill_in;
   logic [BYTE_W-1:0] held_high_ff, held_high_in;
   logic              halted_ff, halted_in;

   always_comb begin
      phase_type          cur_phase;
      logic [LEN_W-1:0]   word;
      logic [LEN_W:0]     sum;
      logic [LEN_W-1:0]   track_ext;
      logic               emit;
      logic [BYTE_W-1:0]  emit_value;
      logic [COUNT_W-1:0] emit_count;
      logic               fail;
      logic [ERR_W-1:0]   fail_code;

      phase_in       = phase_ff;
      packed_left_in = packed_left_ff;
      bytes_made_in  = bytes_made_ff;
      raw_track_in   = raw_track_ff;
      held_fill_in   = held_fill_ff;
      held_high_in   = held_high_ff;
      halted_in      = halted_ff;
      cur_phase      = phase_ff;
      word           = {held_high_ff, req.stream_byte};
      track_ext      = {1'b0, track_bytes};
      sum            = '0;
      emit           = 1'b0;
      emit_value     = '0;
      emit_count     = '0;
      fail           = 1'b0;
      fail_code      = ERR_OK;
      produce        = 1'b0;
      result         = '0;

      if (req.restart) begin
         halted_in = 1'b0;
         cur_phase = PH_LEN_HI;
      end

      if (!halted_in) begin
         case (cur_phase)
            PH_LEN_LO: begin
               packed_left_in = word;
               bytes_made_in  = '0;
               if (word == '0 || word > track_ext) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_LEN;
               end else begin
                  raw_track_in = (word == track_ext);
                  phase_in     = PH_DATA;
               end
            end
            PH_DATA: begin
               if (raw_track_ff || req.stream_byte != RUN_MARKER) begin
                  sum            = {1'b0, bytes_made_ff} + {{LEN_W{1'b0}}, 1'b1};
                  packed_left_in = packed_left_ff - {{(LEN_W-1){1'b0}}, 1'b1};
                  bytes_made_in  = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
                  emit           = 1'b1;
                  emit_value     = req.stream_byte;
                  emit_count     = {{(COUNT_W-1){1'b0}}, 1'b1};
                  phase_in       = PH_DATA;
               end else if (packed_left_ff < GROUP_BYTES) begin
                  fail      = 1'b1;
                  fail_code = ERR_TRUNCATED;
               end else begin
                  packed_left_in = packed_left_ff - GROUP_BYTES;
                  phase_in       = PH_FILL;
               end
            end
            PH_FILL: begin
               held_fill_in = req.stream_byte;
               phase_in     = PH_CNT_HI;
            end
            PH_CNT_HI: begin
               held_high_in = req.stream_byte;
               phase_in     = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               sum = {1'b0, bytes_made_ff} + {1'b0, word};
               if (word == '0 || sum > {1'b0, track_ext}) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_RUN;
               end else begin
                  bytes_made_in = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
                  phase_in      = PH_DATA;
                  emit          = 1'b1;
                  emit_value    = held_fill_ff;
                  emit_count    = word[COUNT_W-1:0];
               end
            end
            default: begin
               held_high_in = req.stream_byte;
               phase_in     = PH_LEN_LO;
            end
         endcase

         if (emit) begin
            produce           = 1'b1;
            result.run_value  = emit_value;
            result.run_count  = emit_count;
            result.error_code = ERR_OK;
            if (packed_left_in == '0) begin
               phase_in = PH_LEN_HI;
               if (bytes_made_in != track_ext) begin
                  fail      = 1'b1;
                  fail_code = ERR_MISMATCH;
               end else begin
                  result.track_done = 1'b1;
               end
            end
         end

         if (fail) begin
            produce           = 1'b1;
            result            = '0;
            result.error_code = fail_code;
            halted_in         = 1'b1;
            phase_in          = PH_LEN_HI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN_HI;
         packed_left_ff <= '0;
         bytes_made_ff  <= '0;
         raw_track_ff   <= 1'b0;
         held_fill_ff   <= '0;
         held_high_ff   <= '0;
         halted_ff      <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         packed_left_ff <= packed_left_in;
         bytes_made_ff  <= bytes_made_in;
         raw_track_ff   <= raw_track_in;
         held_fill_ff   <= held_fill_in;
         held_high_ff   <= held_high_in;
         halted_ff      <= halted_in;
      end
   end

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && !req.restart) |-> !produce)
      else $error("halted decoder produced a result");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (step && produce && result.error_code != ERR_OK) |=> (halted_ff && phase_ff == PH_LEN_HI))
      else $error("error result did not halt the decoder");

   a_error_zero_run: assert property (@(posedge clock) disable iff (reset)
      (produce && result.error_code != ERR_OK) |->
         (result.run_count == '0 && !result.track_done))
      else $error("error result carries a run");

   a_ok_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (produce && result.error_code == ERR_OK) |-> (result.run_count != '0))
      else $error("good result with empty run");

   a_group_not_raw: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FILL || phase_ff == PH_CNT_HI || phase_ff == PH_CNT_LO) |->
         !raw_track_ff)
      else $error("run group open on a raw track");

endmodule

/* hdl/msa_track_rle_decoder.sv */
// ----------------------------------------------------------------------------
// msa_track_rle_decoder
// Decodes track streams of a disk archive into run descriptors.
// ----------------------------------------------------------------------------
// The req channel takes one stream byte per word, with a restart flag that
// marks the first byte of a track header. The rsp channel delivers run
// descriptors (value, count, last-run flag, error code); length bytes and
// group bytes produce no word. Both channels use valid and stall.
// The csr channel writes the expanded track size and is always ready.
// An accepted byte sits in the input register and is decoded in a single
// pass into the result register, where its result becomes valid. One byte
// per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result holds in its register and the byte in
// the input register waits; req_stall rises only while both are occupied and
// rsp_stall is high.
// Synchronous reset empties both registers, sets the track size to 4608 and
// puts the decoder at the start of a track header.
// ----------------------------------------------------------------------------
module msa_track_rle_decoder
   import mtrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic [COUNT_W-1:0] track_bytes_ff;
   logic               out_free;
   logic               step;
   logic               produce;
   rsp_type            result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_valid_in = step ? produce : (rsp_valid_ff && rsp_stall);

   mtrd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (in_data_ff),
      .track_bytes (track_bytes_ff),
      .produce     (produce),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         track_bytes_ff <= TRACK_BYTES_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            track_bytes_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (step && produce) begin
         rsp_data_ff <= result;
      end
   end

endmodule
